/* hdl/abcs_pkg.sv */
// ----------------------------------------------------------------------------
// Air-blow cleaning sequencer package
// Phase codes, register indexes, field widths and the result record shared by
// the sequencer RTL.
// ----------------------------------------------------------------------------
package abcs_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned AdcW  = 12;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PhaseW-1:0] PhaseWarmup      = 3'd0;
  localparam logic [PhaseW-1:0] PhaseRelease     = 3'd1;
  localparam logic [PhaseW-1:0] PhaseReleaseWait = 3'd2;
  localparam logic [PhaseW-1:0] PhaseCharge      = 3'd3;
  localparam logic [PhaseW-1:0] PhaseChargeWait  = 3'd4;
  localparam logic [PhaseW-1:0] PhaseRestart     = 3'd5;

  localparam logic [CfgIdxW-1:0] RegReleaseEnd = 3'd0;
  localparam logic [CfgIdxW-1:0] RegReadEnd    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegChargeEnd  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCycleEnd   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPumpMin    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPumpMax    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegValveMin   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegValveMax   = 3'd7;

  typedef struct packed {
    logic              pump_on;
    logic              valve1_on;
    logic              valve2_on;
    logic [PhaseW-1:0] phase;
    logic              data_valid;
    logic              send_pulse;
    logic              pump_fault;
    logic              valve_fault;
    logic              device_fault;
  } result_t;

  function automatic logic [TimeW-1:0] sat_inc(input logic [TimeW-1:0] v);
    logic [TimeW-1:0] r;
    r = (v == {TimeW{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

  function automatic logic outside(input logic [AdcW-1:0] v,
                                   input logic [AdcW-1:0] lo,
                                   input logic [AdcW-1:0] hi);
    logic r;
    r = (v > hi) || (v < lo);
    return r;
  endfunction

endpackage

/* hdl/air_blow_cleaning_sequencer.sv */
// ----------------------------------------------------------------------------
// Air-blow cleaning sequencer
// Steps a warm-up and a repeating release/charge cycle once per tick
// transaction and checks pump and valve readings against their windows.
// ----------------------------------------------------------------------------
// Each input transaction is one tick; the complete update of the sequencer
// state is computed in the cycle the tick is accepted and its result is
// registered, so a new tick is accepted in every cycle while input stall is
// low. A one-entry skid register behind the output register keeps input
// acceptance going while a result waits; input stall rises only when both are
// full. Configuration writes take effect at the next clock edge.
module air_blow_cleaning_sequencer #(
  parameter int unsigned WARMUP_TICKS = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [abcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [abcs_pkg::TimeW-1:0]    cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_request_i,
  input  logic [abcs_pkg::AdcW-1:0]     pump_adc_i,
  input  logic [abcs_pkg::AdcW-1:0]     valve1_adc_i,
  input  logic [abcs_pkg::AdcW-1:0]     valve2_adc_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pump_on_o,
  output logic                          valve1_on_o,
  output logic                          valve2_on_o,
  output logic [abcs_pkg::PhaseW-1:0]   phase_o,
  output logic                          data_valid_o,
  output logic                          send_pulse_o,
  output logic                          pump_fault_o,
  output logic                          valve_fault_o,
  output logic                          device_fault_o
);

  localparam logic [abcs_pkg::TimeW-1:0] WarmupLim = abcs_pkg::TimeW'(WARMUP_TICKS);

  logic [abcs_pkg::TimeW-1:0] release_end_q, read_end_q, charge_end_q, cycle_end_q;
  logic [abcs_pkg::AdcW-1:0]  pump_min_q, pump_max_q, valve_min_q, valve_max_q;

  logic                       in_warmup_q, in_warmup_d;
  logic [abcs_pkg::TimeW-1:0] elapsed_q, elapsed_d;
  logic                       start_pend_q, start_pend_d;
  logic                       releasing_q, releasing_d;
  logic                       charging_q, charging_d;
  logic                       data_rdy_q, data_rdy_d;
  logic                       pump_bad_q, pump_bad_d;
  logic                       valve_bad_q, valve_bad_d;
  logic                       drv_pump_q, drv_pump_d;
  logic                       drv_v1_q, drv_v1_d;
  logic                       drv_v2_q, drv_v2_d;

  logic                       out_valid_q, skid_valid_q;
  abcs_pkg::result_t          out_q, skid_q, res;

  logic                       in_accept, out_take;
  logic [abcs_pkg::TimeW-1:0] e;
  logic [abcs_pkg::PhaseW-1:0] phase;
  logic                       send, pump_check, valve_check;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_end_q <= '0;
      read_end_q    <= '0;
      charge_end_q  <= '0;
      cycle_end_q   <= '0;
      pump_min_q    <= '0;
      pump_max_q    <= '1;
      valve_min_q   <= '0;
      valve_max_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        abcs_pkg::RegReleaseEnd: release_end_q <= cfg_data_i;
        abcs_pkg::RegReadEnd:    read_end_q    <= cfg_data_i;
        abcs_pkg::RegChargeEnd:  charge_end_q  <= cfg_data_i;
        abcs_pkg::RegCycleEnd:   cycle_end_q   <= cfg_data_i;
        abcs_pkg::RegPumpMin:    pump_min_q    <= cfg_data_i[abcs_pkg::AdcW-1:0];
        abcs_pkg::RegPumpMax:    pump_max_q    <= cfg_data_i[abcs_pkg::AdcW-1:0];
        abcs_pkg::RegValveMin:   valve_min_q   <= cfg_data_i[abcs_pkg::AdcW-1:0];
        abcs_pkg::RegValveMax:   valve_max_q   <= cfg_data_i[abcs_pkg::AdcW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_warmup_d  = in_warmup_q;
    elapsed_d    = elapsed_q;
    start_pend_d = start_pend_q | start_request_i;
    releasing_d  = releasing_q;
    charging_d   = charging_q;
    data_rdy_d   = data_rdy_q;
    drv_pump_d   = drv_pump_q;
    drv_v1_d     = drv_v1_q;
    drv_v2_d     = drv_v2_q;
    phase        = abcs_pkg::PhaseWarmup;
    send         = 1'b0;
    pump_check   = 1'b0;
    valve_check  = 1'b0;
    e            = elapsed_q;

    if (in_warmup_q) begin
      if (elapsed_q < WarmupLim) begin
        drv_pump_d = 1'b1;
        drv_v1_d   = 1'b0;
        drv_v2_d   = 1'b1;
        elapsed_d  = abcs_pkg::sat_inc(elapsed_q);
      end else begin
        in_warmup_d = 1'b0;
        elapsed_d   = '0;
      end
    end else begin
      if (start_pend_d) begin
        e            = '0;
        start_pend_d = 1'b0;
      end
      if (e < release_end_q) begin
        valve_check = !releasing_q;
        drv_pump_d  = 1'b0;
        drv_v1_d    = 1'b1;
        drv_v2_d    = 1'b1;
        releasing_d = 1'b1;
        charging_d  = 1'b0;
        phase       = abcs_pkg::PhaseRelease;
        elapsed_d   = abcs_pkg::sat_inc(e);
      end else if (e < read_end_q) begin
        drv_pump_d  = 1'b0;
        drv_v1_d    = 1'b0;
        drv_v2_d    = 1'b0;
        releasing_d = 1'b0;
        charging_d  = 1'b0;
        data_rdy_d  = 1'b0;
        phase       = abcs_pkg::PhaseReleaseWait;
        elapsed_d   = abcs_pkg::sat_inc(e);
      end else if (e < charge_end_q) begin
        send        = !data_rdy_q;
        data_rdy_d  = 1'b1;
        pump_check  = !charging_q;
        drv_pump_d  = !valve_bad_q;
        drv_v1_d    = 1'b0;
        drv_v2_d    = 1'b1;
        releasing_d = 1'b0;
        charging_d  = 1'b1;
        phase       = abcs_pkg::PhaseCharge;
        elapsed_d   = abcs_pkg::sat_inc(e);
      end else if (e < cycle_end_q) begin
        drv_pump_d  = 1'b0;
        drv_v1_d    = 1'b0;
        drv_v2_d    = 1'b0;
        releasing_d = 1'b0;
        charging_d  = 1'b0;
        phase       = abcs_pkg::PhaseChargeWait;
        elapsed_d   = abcs_pkg::sat_inc(e);
      end else begin
        phase     = abcs_pkg::PhaseRestart;
        elapsed_d = abcs_pkg::TimeW'(1);
      end
    end

    pump_bad_d = pump_check
               ? abcs_pkg::outside(pump_adc_i, pump_min_q, pump_max_q) : pump_bad_q;
    valve_bad_d = valve_check
                ? (abcs_pkg::outside(valve1_adc_i, valve_min_q, valve_max_q) ||
                   abcs_pkg::outside(valve2_adc_i, valve_min_q, valve_max_q))
                : valve_bad_q;

    res.pump_on      = drv_pump_d;
    res.valve1_on    = drv_v1_d;
    res.valve2_on    = drv_v2_d;
    res.phase        = phase;
    res.data_valid   = data_rdy_d;
    res.send_pulse   = send;
    res.pump_fault   = pump_bad_d;
    res.valve_fault  = valve_bad_d;
    res.device_fault = pump_bad_d | valve_bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_warmup_q  <= 1'b1;
      elapsed_q    <= '0;
      start_pend_q <= 1'b1;
      releasing_q  <= 1'b0;
      charging_q   <= 1'b0;
      data_rdy_q   <= 1'b1;
      pump_bad_q   <= 1'b0;
      valve_bad_q  <= 1'b0;
      drv_pump_q   <= 1'b1;
      drv_v1_q     <= 1'b0;
      drv_v2_q     <= 1'b1;
    end else if (in_accept) begin
      in_warmup_q  <= in_warmup_d;
      elapsed_q    <= elapsed_d;
      start_pend_q <= start_pend_d;
      releasing_q  <= releasing_d;
      charging_q   <= charging_d;
      data_rdy_q   <= data_rdy_d;
      pump_bad_q   <= pump_bad_d;
      valve_bad_q  <= valve_bad_d;
      drv_pump_q   <= drv_pump_d;
      drv_v1_q     <= drv_v1_d;
      drv_v2_q     <= drv_v2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pump_on_o      = out_q.pump_on;
  assign valve1_on_o    = out_q.valve1_on;
  assign valve2_on_o    = out_q.valve2_on;
  assign phase_o        = out_q.phase;
  assign data_valid_o   = out_q.data_valid;
  assign send_pulse_o   = out_q.send_pulse;
  assign pump_fault_o   = out_q.pump_fault;
  assign valve_fault_o  = out_q.valve_fault;
  assign device_fault_o = out_q.device_fault;

  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  // A send pulse only comes out of a charge tick that sets data valid.
  a_send_in_charge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_pulse_o) |->
      (data_valid_o && phase_o == abcs_pkg::PhaseCharge))
    else $error("send pulse outside of a charge tick");

  // Warm-up ticks drive the pump and valve 2 with valve 1 closed.
  a_warmup_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && phase_o == abcs_pkg::PhaseWarmup) |->
      (pump_on_o && !valve1_on_o && valve2_on_o))
    else $error("warm-up result with wrong drives");

  // Once the warm-up is over it never comes back before reset.
  a_warmup_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_warmup_q |=> !in_warmup_q)
    else $error("warm-up re-entered");

endmodule

/* tb/sv/air_blow_cleaning_sequencer_test.sv */
// ----------------------------------------------------------------------------
// Air-blow cleaning sequencer testbench
// Drives tick transactions through the sequencer under a range of phase
// boundaries and fault windows. A short directed table covers the warm-up,
// fault detection and restart behavior, then randomized phases follow.
// Every result is compared field by field, the typed warm-up rows against
// their table record and all others against an in-bench model of the cycle.
// ----------------------------------------------------------------------------
module air_blow_cleaning_sequencer_test;

  localparam int WarmupTicks = 9;
  localparam int StallLimit  = 1000;

  typedef struct packed {
    logic                      req;
    logic [abcs_pkg::AdcW-1:0] pump;
    logic [abcs_pkg::AdcW-1:0] valve1;
    logic [abcs_pkg::AdcW-1:0] valve2;
    logic                      typed;
    abcs_pkg::result_t         want;
  } tick_row_t;

  localparam abcs_pkg::result_t WarmRes = '{1'b1, 1'b0, 1'b1, abcs_pkg::PhaseWarmup,
                                            1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam abcs_pkg::result_t NoRes   = '0;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [abcs_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [abcs_pkg::TimeW-1:0]   cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         start_request_i;
  logic [abcs_pkg::AdcW-1:0]    pump_adc_i;
  logic [abcs_pkg::AdcW-1:0]    valve1_adc_i;
  logic [abcs_pkg::AdcW-1:0]    valve2_adc_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic                         pump_on_o;
  logic                         valve1_on_o;
  logic                         valve2_on_o;
  logic [abcs_pkg::PhaseW-1:0]  phase_o;
  logic                         data_valid_o;
  logic                         send_pulse_o;
  logic                         pump_fault_o;
  logic                         valve_fault_o;
  logic                         device_fault_o;

  logic                       seq_warm;
  logic [abcs_pkg::TimeW-1:0] seq_elapsed;
  logic                       seq_pending;
  logic                       seq_releasing;
  logic                       seq_charging;
  logic                       seq_ready;
  logic                       seq_pump_bad;
  logic                       seq_valve_bad;
  logic                       drv_pump;
  logic                       drv_v1;
  logic                       drv_v2;

  logic [abcs_pkg::TimeW-1:0] lim_release;
  logic [abcs_pkg::TimeW-1:0] lim_read;
  logic [abcs_pkg::TimeW-1:0] lim_charge;
  logic [abcs_pkg::TimeW-1:0] lim_cycle;
  logic [abcs_pkg::AdcW-1:0]  pump_lo;
  logic [abcs_pkg::AdcW-1:0]  pump_hi;
  logic [abcs_pkg::AdcW-1:0]  valve_lo;
  logic [abcs_pkg::AdcW-1:0]  valve_hi;

  abcs_pkg::result_t expected_results[$];
  int unsigned       mismatches = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       gap_max = 8;

  tick_row_t directed_ticks [25] = '{
    '{1'b0, 12'd0,    12'd0,    12'd0,    1'b1, WarmRes},
    '{1'b1, 12'd4095, 12'd4095, 12'd4095, 1'b1, WarmRes},
    '{1'b0, 12'd0,    12'd4095, 12'd0,    1'b1, WarmRes},
    '{1'b0, 12'd4095, 12'd0,    12'd4095, 1'b1, WarmRes},
    '{1'b0, 12'd1234, 12'd2345, 12'd3456, 1'b1, WarmRes},
    '{1'b0, 12'd0,    12'd0,    12'd0,    1'b1, WarmRes},
    '{1'b0, 12'd4095, 12'd4095, 12'd4095, 1'b1, WarmRes},
    '{1'b0, 12'd2048, 12'd2048, 12'd2048, 1'b1, WarmRes},
    '{1'b0, 12'd1,    12'd1,    12'd1,    1'b1, WarmRes},
    '{1'b0, 12'd4094, 12'd4094, 12'd4094, 1'b1, WarmRes},
    '{1'b0, 12'd0,    12'd0,    12'd0,    1'b0, NoRes},
    '{1'b0, 12'd4095, 12'd4095, 12'd4095, 1'b0, NoRes},
    '{1'b0, 12'd500,  12'd500,  12'd500,  1'b0, NoRes},
    '{1'b0, 12'd4095, 12'd500,  12'd500,  1'b0, NoRes},
    '{1'b0, 12'd0,    12'd500,  12'd500,  1'b0, NoRes},
    '{1'b0, 12'd500,  12'd500,  12'd500,  1'b0, NoRes},
    '{1'b0, 12'd500,  12'd500,  12'd500,  1'b0, NoRes},
    '{1'b0, 12'd500,  12'd200,  12'd3500, 1'b0, NoRes},
    '{1'b0, 12'd500,  12'd500,  12'd500,  1'b0, NoRes},
    '{1'b0, 12'd100,  12'd500,  12'd500,  1'b0, NoRes},
    '{1'b1, 12'd3000, 12'd3501, 12'd500,  1'b0, NoRes},
    '{1'b0, 12'd500,  12'd500,  12'd199,  1'b0, NoRes},
    '{1'b0, 12'd500,  12'd500,  12'd500,  1'b0, NoRes},
    '{1'b0, 12'd99,   12'd500,  12'd500,  1'b0, NoRes},
    '{1'b0, 12'd3001, 12'd500,  12'd500,  1'b0, NoRes}
  };

  air_blow_cleaning_sequencer #(
    .WARMUP_TICKS(WarmupTicks)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_request_i(start_request_i),
    .pump_adc_i     (pump_adc_i),
    .valve1_adc_i   (valve1_adc_i),
    .valve2_adc_i   (valve2_adc_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pump_on_o      (pump_on_o),
    .valve1_on_o    (valve1_on_o),
    .valve2_on_o    (valve2_on_o),
    .phase_o        (phase_o),
    .data_valid_o   (data_valid_o),
    .send_pulse_o   (send_pulse_o),
    .pump_fault_o   (pump_fault_o),
    .valve_fault_o  (valve_fault_o),
    .device_fault_o (device_fault_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic abcs_pkg::result_t advance_sequencer(
      input logic req,
      input logic [abcs_pkg::AdcW-1:0] p,
      input logic [abcs_pkg::AdcW-1:0] v1,
      input logic [abcs_pkg::AdcW-1:0] v2);
    abcs_pkg::result_t           r;
    logic [abcs_pkg::PhaseW-1:0] ph;
    logic [abcs_pkg::TimeW-1:0]  e;
    logic                        send;
    logic                        counting;
    logic                        charge_first;
    logic                        release_first;
    ph = abcs_pkg::PhaseWarmup;
    e = seq_elapsed;
    send = 1'b0;
    counting = 1'b0;
    charge_first = 1'b0;
    release_first = 1'b0;
    if (req) begin
      seq_pending = 1'b1;
    end
    if (seq_warm) begin
      if (seq_elapsed < WarmupTicks) begin
        {drv_pump, drv_v1, drv_v2} = 3'b101;
        seq_elapsed = seq_elapsed + 1'b1;
      end else begin
        seq_warm = 1'b0;
        seq_elapsed = '0;
      end
    end else begin
      if (seq_pending) begin
        seq_elapsed = '0;
        seq_pending = 1'b0;
      end
      e = seq_elapsed;
      counting = 1'b1;
      if (e < lim_release) begin
        release_first = !seq_releasing;
        {drv_pump, drv_v1, drv_v2} = 3'b011;
        seq_releasing = 1'b1;
        seq_charging = 1'b0;
        ph = abcs_pkg::PhaseRelease;
      end else if (e < lim_read) begin
        {drv_pump, drv_v1, drv_v2} = 3'b000;
        seq_releasing = 1'b0;
        seq_charging = 1'b0;
        seq_ready = 1'b0;
        ph = abcs_pkg::PhaseReleaseWait;
      end else if (e < lim_charge) begin
        send = !seq_ready;
        seq_ready = 1'b1;
        charge_first = !seq_charging;
        {drv_pump, drv_v1, drv_v2} = {!seq_valve_bad, 2'b01};
        seq_releasing = 1'b0;
        seq_charging = 1'b1;
        ph = abcs_pkg::PhaseCharge;
      end else if (e < lim_cycle) begin
        {drv_pump, drv_v1, drv_v2} = 3'b000;
        seq_releasing = 1'b0;
        seq_charging = 1'b0;
        ph = abcs_pkg::PhaseChargeWait;
      end else begin
        counting = 1'b0;
        ph = abcs_pkg::PhaseRestart;
        seq_elapsed = 16'd1;
      end
    end
    if (counting) begin
      seq_elapsed = (e == '1) ? e : e + 1'b1;
    end
    if (charge_first) begin
      seq_pump_bad = (p < pump_lo) || (p > pump_hi);
    end
    if (release_first) begin
      seq_valve_bad = (v1 < valve_lo) || (v1 > valve_hi) ||
                      (v2 < valve_lo) || (v2 > valve_hi);
    end
    r = '{drv_pump, drv_v1, drv_v2, ph, seq_ready, send, seq_pump_bad, seq_valve_bad,
          seq_pump_bad | seq_valve_bad};
    return r;
  endfunction

  function automatic logic [abcs_pkg::AdcW-1:0] adc_pick(
      input logic [abcs_pkg::AdcW-1:0] lo,
      input logic [abcs_pkg::AdcW-1:0] hi);
    logic [abcs_pkg::AdcW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = lo;
      1: v = hi;
      2: v = (lo == '0) ? lo : lo - 1'b1;
      3: v = (hi == '1) ? hi : hi + 1'b1;
      4: v = (lo <= hi) ? abcs_pkg::AdcW'($urandom_range(lo, hi))
                        : abcs_pkg::AdcW'($urandom);
      default: v = abcs_pkg::AdcW'($urandom);
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [abcs_pkg::CfgIdxW-1:0] idx,
                           input logic [abcs_pkg::TimeW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Lets the block drain completely; every tick yields one result.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [abcs_pkg::TimeW-1:0] rel,
                                input logic [abcs_pkg::TimeW-1:0] rd,
                                input logic [abcs_pkg::TimeW-1:0] chg,
                                input logic [abcs_pkg::TimeW-1:0] cyc,
                                input logic [abcs_pkg::AdcW-1:0] plo,
                                input logic [abcs_pkg::AdcW-1:0] phi,
                                input logic [abcs_pkg::AdcW-1:0] vlo,
                                input logic [abcs_pkg::AdcW-1:0] vhi);
    settle();
    write_reg(abcs_pkg::RegReleaseEnd, rel);
    write_reg(abcs_pkg::RegReadEnd, rd);
    write_reg(abcs_pkg::RegChargeEnd, chg);
    write_reg(abcs_pkg::RegCycleEnd, cyc);
    write_reg(abcs_pkg::RegPumpMin, abcs_pkg::TimeW'(plo));
    write_reg(abcs_pkg::RegPumpMax, abcs_pkg::TimeW'(phi));
    write_reg(abcs_pkg::RegValveMin, abcs_pkg::TimeW'(vlo));
    write_reg(abcs_pkg::RegValveMax, abcs_pkg::TimeW'(vhi));
    cfg_we_i <= 1'b0;
    lim_release = rel;
    lim_read = rd;
    lim_charge = chg;
    lim_cycle = cyc;
    pump_lo = plo;
    pump_hi = phi;
    valve_lo = vlo;
    valve_hi = vhi;
  endtask

  task automatic send_tick(input logic req, input logic [abcs_pkg::AdcW-1:0] p,
                           input logic [abcs_pkg::AdcW-1:0] v1,
                           input logic [abcs_pkg::AdcW-1:0] v2,
                           input logic typed, input abcs_pkg::result_t want);
    int unsigned       gap;
    abcs_pkg::result_t predicted;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_request_i <= req;
    pump_adc_i <= p;
    valve1_adc_i <= v1;
    valve2_adc_i <= v2;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_sequencer(req, p, v1, v2);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic run_random_ticks(input int count);
    for (int n = 0; n < count; n++) begin
      send_tick($urandom_range(0, 49) == 0, adc_pick(pump_lo, pump_hi),
                adc_pick(valve_lo, valve_hi), adc_pick(valve_lo, valve_hi), 1'b0, NoRes);
    end
  endtask

  task automatic random_phase(input int count);
    logic [abcs_pkg::TimeW-1:0] b0, b1, b2, b3;
    logic [abcs_pkg::AdcW-1:0]  plo, phi, vlo, vhi;
    if ($urandom_range(0, 4) == 0) begin
      b0 = abcs_pkg::TimeW'($urandom_range(0, 20));
      b1 = abcs_pkg::TimeW'($urandom_range(0, 20));
      b2 = abcs_pkg::TimeW'($urandom_range(0, 20));
      b3 = abcs_pkg::TimeW'($urandom_range(0, 20));
    end else begin
      b0 = abcs_pkg::TimeW'($urandom_range(0, 6));
      b1 = abcs_pkg::TimeW'(b0 + $urandom_range(0, 5));
      b2 = abcs_pkg::TimeW'(b1 + $urandom_range(0, 6));
      b3 = abcs_pkg::TimeW'(b2 + $urandom_range(0, 6));
    end
    plo = abcs_pkg::AdcW'($urandom_range(0, 4095));
    phi = abcs_pkg::AdcW'($urandom_range(plo, 4095));
    vlo = abcs_pkg::AdcW'($urandom_range(0, 4095));
    vhi = abcs_pkg::AdcW'($urandom_range(vlo, 4095));
    if ($urandom_range(0, 5) == 0) begin
      {plo, phi} = {phi, plo};
    end
    if ($urandom_range(0, 5) == 0) begin
      {vlo, vhi} = {vhi, vlo};
    end
    apply_settings(b0, b1, b2, b3, plo, phi, vlo, vhi);
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    run_random_ticks(count);
  endtask

  initial begin
    int unsigned taken;
    int unsigned hold;
    taken = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = $urandom_range(0, gap_max);
      if (gap_max != 0 && taken % 400 == 399) begin
        hold = 150;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    abcs_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("pump_on", 32'(want.pump_on), 32'(pump_on_o));
        check_field("valve1_on", 32'(want.valve1_on), 32'(valve1_on_o));
        check_field("valve2_on", 32'(want.valve2_on), 32'(valve2_on_o));
        check_field("phase", 32'(want.phase), 32'(phase_o));
        check_field("data_valid", 32'(want.data_valid), 32'(data_valid_o));
        check_field("send_pulse", 32'(want.send_pulse), 32'(send_pulse_o));
        check_field("pump_fault", 32'(want.pump_fault), 32'(pump_fault_o));
        check_field("valve_fault", 32'(want.valve_fault), 32'(valve_fault_o));
        check_field("device_fault", 32'(want.device_fault), 32'(device_fault_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= abcs_pkg::RegReleaseEnd;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    start_request_i <= 1'b0;
    pump_adc_i <= '0;
    valve1_adc_i <= '0;
    valve2_adc_i <= '0;
    seq_warm = 1'b1;
    seq_elapsed = '0;
    seq_pending = 1'b1;
    seq_releasing = 1'b0;
    seq_charging = 1'b0;
    seq_ready = 1'b1;
    seq_pump_bad = 1'b0;
    seq_valve_bad = 1'b0;
    {drv_pump, drv_v1, drv_v2} = 3'b101;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_settings(16'd2, 16'd3, 16'd5, 16'd6, 12'd100, 12'd3000, 12'd200, 12'd3500);
    foreach (directed_ticks[i]) begin
      send_tick(directed_ticks[i].req, directed_ticks[i].pump, directed_ticks[i].valve1,
                directed_ticks[i].valve2, directed_ticks[i].typed, directed_ticks[i].want);
    end

    apply_settings(16'd3, 16'd5, 16'd8, 16'd10, 12'd500, 12'd3500, 12'd300, 12'd3800);
    run_random_ticks(150);
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd4095, 12'd0, 12'd4095);
    run_random_ticks(60);
    apply_settings(16'd6, 16'd2, 16'd12, 16'd9, 12'd3000, 12'd1000, 12'd2048, 12'd2048);
    run_random_ticks(150);
    apply_settings(16'd0, 16'd4, 16'd4, 16'd7, 12'd0, 12'd0, 12'd4095, 12'd4095);
    run_random_ticks(150);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd1, 12'd4094, 12'd1, 12'd4094);
    run_random_ticks(60);

    for (int k = 0; k < 10; k++) begin
      random_phase(120);
    end

    gap_max = 8;
    run_random_ticks(40);

    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* air_blow_cleaning_sequencer.f */
hdl/abcs_pkg.sv
hdl/air_blow_cleaning_sequencer.sv
tb/sv/air_blow_cleaning_sequencer_test.sv
